@@ sv/kbp_pkg.sv @@
// Shared types and codes for the keyed block pool.
`default_nettype none
package kbp_pkg;

  // Default pool depth.
  localparam int BLOCKS_DEFAULT = 32;

  // Field widths fixed by the interface.
  localparam int MODE_W   = 2;
  localparam int KEY_W    = 64;
  localparam int FRAME_W  = 32;
  localparam int STATUS_W = 3;
  localparam int BASE_W   = 13;
  localparam int CFG_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int SLOTS_FIELD_W = 6;

  // Largest layer count.
  localparam int LAYERS_MAX = 256;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_ACQUIRE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FREE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EVICT    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd6;
  localparam logic [STATUS_W-1:0] ST_RELMISS  = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYERS = 2'd1;

  // Search flags that travel along the cell row with the scan beat.
  typedef struct packed {
    logic tok;
    logic hit;
    logic free;
    logic cand;
  } scan_flags_t;

  // Slot update broadcast to the cells.
  typedef enum logic [1:0] {
    WR_FILL,
    WR_TOUCH,
    WR_FREE
  } wr_op_t;

  typedef struct packed {
    logic   en;
    wr_op_t op;
  } wr_cmd_t;

endpackage
`default_nettype wire

@@ sv/kbp_cell.sv @@
// One pool slot: holds valid, owner and age, and folds itself into the passing scan.
`default_nettype none
module kbp_cell #(
  parameter int BLOCKS = 32,
  parameter int IDX    = 0,
  localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1,
  localparam int CW = $clog2(BLOCKS + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         clear,
  input  wire logic [CW-1:0]                count,
  input  wire logic [kbp_pkg::KEY_W-1:0]    key,
  input  wire logic [kbp_pkg::FRAME_W-1:0]  frame,
  input  wire kbp_pkg::wr_cmd_t             wr_cmd,
  input  wire logic [IW-1:0]                wr_idx,
  input  wire kbp_pkg::scan_flags_t         flags_in,
  input  wire logic [IW-1:0]                hit_idx_in,
  input  wire logic [IW-1:0]                free_idx_in,
  input  wire logic [IW-1:0]                cand_idx_in,
  input  wire logic [kbp_pkg::FRAME_W-1:0]  cand_age_in,
  input  wire logic [kbp_pkg::KEY_W-1:0]    cand_owner_in,
  output kbp_pkg::scan_flags_t              flags_out,
  output logic [IW-1:0]                     hit_idx_out,
  output logic [IW-1:0]                     free_idx_out,
  output logic [IW-1:0]                     cand_idx_out,
  output logic [kbp_pkg::FRAME_W-1:0]       cand_age_out,
  output logic [kbp_pkg::KEY_W-1:0]         cand_owner_out
);
  import kbp_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic               valid;
  logic [KEY_W-1:0]   owner;
  logic [FRAME_W-1:0] age;

  logic               enabled;
  scan_flags_t        flags_next;
  logic [IW-1:0]      hit_idx_next;
  logic [IW-1:0]      free_idx_next;
  logic [IW-1:0]      cand_idx_next;
  logic [FRAME_W-1:0] cand_age_next;
  logic [KEY_W-1:0]   cand_owner_next;

  assign enabled = (CW'(IDX) < count);

  // Fold this slot into the running search.
  always_comb begin
    flags_next      = flags_in;
    hit_idx_next    = hit_idx_in;
    free_idx_next   = free_idx_in;
    cand_idx_next   = cand_idx_in;
    cand_age_next   = cand_age_in;
    cand_owner_next = cand_owner_in;
    if (flags_in.tok && enabled) begin
      if (valid && (owner == key) && !flags_in.hit) begin
        flags_next.hit = 1'b1;
        hit_idx_next   = MY_IDX;
      end
      if (!valid && !flags_in.free) begin
        flags_next.free = 1'b1;
        free_idx_next   = MY_IDX;
      end
      if ((age < frame) && (!flags_in.cand || (age < cand_age_in))) begin
        flags_next.cand = 1'b1;
        cand_idx_next   = MY_IDX;
        cand_age_next   = age;
        cand_owner_next = owner;
      end
    end
  end

  // Hand the search to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags_out <= '0;
    end else begin
      flags_out <= flags_next;
    end
    hit_idx_out    <= hit_idx_next;
    free_idx_out   <= free_idx_next;
    cand_idx_out   <= cand_idx_next;
    cand_age_out   <= cand_age_next;
    cand_owner_out <= cand_owner_next;
  end

  // Slot state: cleared by reset or a slot count write, updated by the commit broadcast.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (wr_cmd.en && (wr_idx == MY_IDX)) begin
      unique case (wr_cmd.op)
        WR_FILL: begin
          valid <= 1'b1;
          owner <= key;
          age   <= frame;
        end
        WR_TOUCH: begin
          age <= frame;
        end
        WR_FREE: begin
          valid <= 1'b0;
        end
        default: begin
          valid <= valid;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/keyed_block_pool_lru_frame.sv @@
// Top level of the keyed block pool with LRU replacement and frame protection.
//
// Requests arrive on the s_ channel, one beat per request (mode, key, frame).
// Each request gives exactly one result beat on the m_ channel (status,
// layer base, evicted key). Configuration goes through the cfg_ write port:
// index 0 sets the slot count and clears the table, index 1 the layers per
// block; other indexes are ignored. Write only while no request is in flight.
// A request is scanned through a row of BLOCKS slot cells, one cell per
// cycle, so the chain length sets the timing. The next request is taken
// once the sequencer is back in idle, after the previous result has been
// loaded into the output register. The decision and slot update happen
// when the scan leaves the last cell; the layer base multiply follows in
// the S_MUL state.
// A stalled result waits in the output register while the next request is
// accepted and scanned; its own result then waits for the register to free.
// Synchronous reset empties the table and restores slot count BLOCKS and
// one layer per block; s_tready stays low while reset is held.
`default_nettype none
module keyed_block_pool_lru_frame #(
  parameter int BLOCKS = kbp_pkg::BLOCKS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Request beat, lowest bits first: mode[1:0], key[65:2], frame_number[97:66], zero pad.
  input  wire logic [103:0]                    s_tdata,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // Result beat, lowest bits first: status[2:0], layer_base[15:3], evicted_key[79:16].
  output logic [79:0]                          m_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  input  wire logic                            cfg_we,
  input  wire logic [kbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [kbp_pkg::CFG_W-1:0]       cfg_data
);
  import kbp_pkg::*;

  localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CW = $clog2(BLOCKS + 1);
  localparam int PW = IW + CFG_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MUL
  } state_t;

  state_t state;

  // Configuration registers.
  logic [CW-1:0]    slot_count;
  logic [CFG_W-1:0] layers;
  logic             cfg_clear;
  logic [SLOTS_FIELD_W-1:0] slots_field;

  // Held request.
  logic [MODE_W-1:0]  it_mode;
  logic [KEY_W-1:0]   it_key;
  logic [FRAME_W-1:0] it_frame;

  // Scan launch and cell row links.
  scan_flags_t        launch;
  scan_flags_t        launch_next;
  scan_flags_t        fl   [BLOCKS+1];
  logic [IW-1:0]      hidx [BLOCKS+1];
  logic [IW-1:0]      fidx [BLOCKS+1];
  logic [IW-1:0]      cidx [BLOCKS+1];
  logic [FRAME_W-1:0] cage [BLOCKS+1];
  logic [KEY_W-1:0]   cown [BLOCKS+1];

  // Decision and commit.
  wr_cmd_t            wr_cmd;
  logic [IW-1:0]      wr_idx;
  logic [STATUS_W-1:0] dec_status;
  logic [IW-1:0]      dec_pick;
  logic [KEY_W-1:0]   dec_evk;
  logic               scan_done;

  logic [STATUS_W-1:0] res_status;
  logic [IW-1:0]      res_pick;
  logic [KEY_W-1:0]   res_evk;
  logic [PW-1:0]      product;

  assign s_tready    = (state == S_IDLE) && !rst;
  assign cfg_clear   = cfg_we && (cfg_index == CFG_SLOTS);
  assign slots_field = cfg_data[SLOTS_FIELD_W-1:0];

  // Configuration writes with clamping.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= CW'(BLOCKS);
      layers     <= CFG_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == CFG_SLOTS) begin
        if (int'(slots_field) > BLOCKS) begin
          slot_count <= CW'(BLOCKS);
        end else begin
          slot_count <= CW'(slots_field);
        end
      end else if (cfg_index == CFG_LAYERS) begin
        if (cfg_data == '0) begin
          layers <= CFG_W'(1);
        end else if (int'(cfg_data) > LAYERS_MAX) begin
          layers <= CFG_W'(LAYERS_MAX);
        end else begin
          layers <= cfg_data;
        end
      end
    end
  end

  // Head of the cell row.
  assign fl[0]   = launch;
  assign hidx[0] = '0;
  assign fidx[0] = '0;
  assign cidx[0] = '0;
  assign cage[0] = '0;
  assign cown[0] = '0;

  for (genvar i = 0; i < BLOCKS; i++) begin : g_cell
    kbp_cell #(
      .BLOCKS (BLOCKS),
      .IDX    (i)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .clear          (cfg_clear),
      .count          (slot_count),
      .key            (it_key),
      .frame          (it_frame),
      .wr_cmd         (wr_cmd),
      .wr_idx         (wr_idx),
      .flags_in       (fl[i]),
      .hit_idx_in     (hidx[i]),
      .free_idx_in    (fidx[i]),
      .cand_idx_in    (cidx[i]),
      .cand_age_in    (cage[i]),
      .cand_owner_in  (cown[i]),
      .flags_out      (fl[i+1]),
      .hit_idx_out    (hidx[i+1]),
      .free_idx_out   (fidx[i+1]),
      .cand_idx_out   (cidx[i+1]),
      .cand_age_out   (cage[i+1]),
      .cand_owner_out (cown[i+1])
    );
  end

  assign scan_done = (state == S_SCAN) && fl[BLOCKS].tok;

  // Decide the outcome from the search that left the last cell.
  always_comb begin
    dec_status = ST_MISS;
    dec_pick   = '0;
    dec_evk    = '0;
    wr_cmd     = '{en: 1'b0, op: WR_TOUCH};
    wr_idx     = '0;
    unique case (it_mode)
      MODE_ACQUIRE: begin
        if (fl[BLOCKS].hit) begin
          dec_status = ST_HIT;
          dec_pick   = hidx[BLOCKS];
          wr_cmd     = '{en: scan_done, op: WR_TOUCH};
          wr_idx     = hidx[BLOCKS];
        end else if (fl[BLOCKS].free) begin
          dec_status = ST_FREE;
          dec_pick   = fidx[BLOCKS];
          wr_cmd     = '{en: scan_done, op: WR_FILL};
          wr_idx     = fidx[BLOCKS];
        end else if (fl[BLOCKS].cand) begin
          dec_status = ST_EVICT;
          dec_pick   = cidx[BLOCKS];
          dec_evk    = cown[BLOCKS];
          wr_cmd     = '{en: scan_done, op: WR_FILL};
          wr_idx     = cidx[BLOCKS];
        end else begin
          dec_status = ST_FULL;
        end
      end
      MODE_RELEASE: begin
        if (fl[BLOCKS].hit) begin
          dec_status = ST_RELEASED;
          wr_cmd     = '{en: scan_done, op: WR_FREE};
          wr_idx     = hidx[BLOCKS];
        end else begin
          dec_status = ST_RELMISS;
        end
      end
      default: begin
        if (fl[BLOCKS].hit) begin
          dec_status = ST_FOUND;
          dec_pick   = hidx[BLOCKS];
        end else begin
          dec_status = ST_MISS;
        end
      end
    endcase
  end

  assign product = PW'(res_pick) * PW'(layers);

  // A scan beat is launched for each accepted request.
  always_comb begin
    launch_next     = '0;
    launch_next.tok = s_tvalid && s_tready;
  end

  // Request sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launch   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      launch <= launch_next;
      if (m_tvalid && m_tready && (state != S_MUL)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    if (s_tvalid && s_tready) begin
      it_mode  <= s_tdata[1:0];
      it_key   <= s_tdata[65:2];
      it_frame <= s_tdata[97:66];
    end
    if (scan_done) begin
      res_status <= dec_status;
      res_pick   <= dec_pick;
      res_evk    <= dec_evk;
    end
    if ((state == S_MUL) && (!m_tvalid || m_tready)) begin
      m_tdata <= {res_evk, BASE_W'(product), res_status};
    end
  end

`ifndef SYNTHESIS
  // The scan beat leaves the row only while the sequencer waits for it.
  a_scan_in_scan: assert property (@(posedge clk) disable iff (rst)
    fl[BLOCKS].tok |-> (state == S_SCAN))
    else $error("scan beat left the cell row outside a scan");

  // An accepted request starts exactly one scan.
  a_accept_launch: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (launch.tok && (state == S_SCAN)))
    else $error("accepted request did not launch a scan");

  // Outcomes without a block carry a zero layer base.
  a_no_base: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((m_tdata[2:0] == ST_FULL) || (m_tdata[2:0] == ST_MISS) ||
      (m_tdata[2:0] == ST_RELEASED) || (m_tdata[2:0] == ST_RELMISS)))
      |-> (m_tdata[15:3] == '0))
    else $error("layer base set on a result without a block");

  // Only an eviction reports a key.
  a_evk_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[2:0] != ST_EVICT)) |-> (m_tdata[79:16] == '0))
    else $error("evicted key set on a result that is not an eviction");
`endif

endmodule
`default_nettype wire
